FILE: hw/rtl/channel_lock_wait_queue_macros.svh
// ---------------------------------------------------------------------------
// Channel lock wait queue: assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef CHANNEL_LOCK_WAIT_QUEUE_MACROS_SVH
`define CHANNEL_LOCK_WAIT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLWQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("channel lock wait queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLWQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("channel lock wait queue check failed");

`endif

FILE: hw/rtl/clwq_pkg.sv
// ---------------------------------------------------------------------------
// clwq_pkg
// Types, sizes and result codes shared by the channel lock wait queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package clwq_pkg;

    localparam int CHANNELS   = 3;
    localparam int WAIT_DEPTH = 3;

    localparam int CH_W   = 2;
    localparam int DEV_W  = 2;
    localparam int CODE_W = 3;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

    // Request types.
    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;

    // Result codes.
    localparam logic [CODE_W-1:0] RC_OK      = 3'd0;
    localparam logic [CODE_W-1:0] RC_QUEUED  = 3'd1;
    localparam logic [CODE_W-1:0] RC_WAITING = 3'd2;
    localparam logic [CODE_W-1:0] RC_BUSY    = 3'd3;
    localparam logic [CODE_W-1:0] RC_REFUSED = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [CH_W-1:0]  channel;
        logic [DEV_W-1:0] device;
        logic             wants_notify;
    } req_t;

    typedef struct packed {
        logic [CODE_W-1:0] result_code;
        logic              notify_valid;
        logic [DEV_W-1:0]  notify_device;
    } rsp_t;

    // What one cell hands to the next: the item and its result so far.
    typedef struct packed {
        logic valid;
        req_t req;
        rsp_t rsp;
    } stage_t;

endpackage

FILE: hw/rtl/channel_lock_wait_queue.sv
// ---------------------------------------------------------------------------
// channel_lock_wait_queue
// Per-channel bus lock with a FIFO of devices waiting for notification.
// ---------------------------------------------------------------------------
// Each request item travels down a row of cells, one cell per channel, moving
// one cell per clock while the row advances; the cell that owns the addressed
// channel answers it and updates its lock flag and wait list, the others pass
// it on. A new item can enter every cycle, so the block sustains one item per
// clock while results are taken, and each result passes every cell's stage
// register in turn. Requests to a channel number beyond the row pass through
// untouched and are answered as busy (lock) or refused (unlock). The whole row
// stalls together while the last cell holds a result that has not been taken,
// so s_ready follows m_ready whenever a result is waiting. An unlock that
// finds devices waiting releases the lock and reports the oldest waiter for
// notification; it does not hand the lock to that device.
`timescale 1ns / 1ps

module channel_lock_wait_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  clwq_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output clwq_pkg::rsp_t m_data
);

    clwq_pkg::stage_t chain [clwq_pkg::CHANNELS + 1];
    logic             adv;

    // The row moves when the last cell is empty or its result is being taken.
    assign adv     = !chain[clwq_pkg::CHANNELS].valid || m_ready;
    assign s_ready = adv;

    // An item enters with the answer it gets if no cell claims it.
    always_comb begin
        chain[0].valid = s_valid && s_ready;
        chain[0].req   = s_data;
        chain[0].rsp.result_code = (s_data.req_type == clwq_pkg::REQ_UNLOCK)
                                   ? clwq_pkg::RC_REFUSED : clwq_pkg::RC_BUSY;
        chain[0].rsp.notify_valid  = 1'b0;
        chain[0].rsp.notify_device = '0;
    end

    for (genvar k = 0; k < clwq_pkg::CHANNELS; k++) begin : g_cell
        clwq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .cell_id   (clwq_pkg::CH_W'(k)),
            .stage_in  (chain[k]),
            .stage_out (chain[k + 1])
        );
    end

    assign m_valid = chain[clwq_pkg::CHANNELS].valid;
    assign m_data  = chain[clwq_pkg::CHANNELS].rsp;

endmodule

FILE: hw/rtl/clwq_cell.sv
// ---------------------------------------------------------------------------
// clwq_cell
// One channel of the lock: lock flag, wait list and one pipeline stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clwq_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic [clwq_pkg::CH_W-1:0] cell_id,
    input  clwq_pkg::stage_t         stage_in,
    output clwq_pkg::stage_t         stage_out
);

    logic                                    locked_reg;
    logic                                    locked_next;
    logic [clwq_pkg::CNT_W-1:0]              count_reg;
    logic [clwq_pkg::CNT_W-1:0]              count_next;
    logic [clwq_pkg::DEV_W-1:0]              entry_reg  [clwq_pkg::WAIT_DEPTH];
    logic [clwq_pkg::DEV_W-1:0]              entry_next [clwq_pkg::WAIT_DEPTH];
    clwq_pkg::stage_t                        stage_reg;
    clwq_pkg::stage_t                        stage_next;
    logic                                    hit;
    logic                                    dup;

    assign hit = stage_in.valid && (stage_in.req.channel == cell_id);

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < clwq_pkg::WAIT_DEPTH; i++) begin
            if ((clwq_pkg::CNT_W'(i) < count_reg) && (entry_reg[i] == stage_in.req.device)) begin
                dup = 1'b1;
            end
        end
    end

    always_comb begin
        locked_next = locked_reg;
        count_next  = count_reg;
        stage_next  = stage_in;
        for (int i = 0; i < clwq_pkg::WAIT_DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
        end
        if (hit) begin
            if (stage_in.req.req_type == clwq_pkg::REQ_LOCK) begin
                if (!locked_reg) begin
                    locked_next                = 1'b1;
                    stage_next.rsp.result_code = clwq_pkg::RC_OK;
                end else if (!stage_in.req.wants_notify) begin
                    stage_next.rsp.result_code = clwq_pkg::RC_BUSY;
                end else if (dup) begin
                    stage_next.rsp.result_code = clwq_pkg::RC_WAITING;
                end else if (count_reg == clwq_pkg::CNT_W'(clwq_pkg::WAIT_DEPTH)) begin
                    stage_next.rsp.result_code = clwq_pkg::RC_BUSY;
                end else begin
                    for (int i = 0; i < clwq_pkg::WAIT_DEPTH; i++) begin
                        if (clwq_pkg::CNT_W'(i) == count_reg) begin
                            entry_next[i] = stage_in.req.device;
                        end
                    end
                    count_next                 = count_reg + clwq_pkg::CNT_W'(1);
                    stage_next.rsp.result_code = clwq_pkg::RC_QUEUED;
                end
            end else begin
                if (!locked_reg) begin
                    stage_next.rsp.result_code = clwq_pkg::RC_REFUSED;
                end else begin
                    locked_next                = 1'b0;
                    stage_next.rsp.result_code = clwq_pkg::RC_OK;
                    if (count_reg != '0) begin
                        // Pop the oldest waiter; the rest move up one place.
                        stage_next.rsp.notify_valid  = 1'b1;
                        stage_next.rsp.notify_device = entry_reg[0];
                        for (int i = 0; i < clwq_pkg::WAIT_DEPTH - 1; i++) begin
                            entry_next[i] = entry_reg[i + 1];
                        end
                        count_next = count_reg - clwq_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg      <= 1'b0;
            count_reg       <= '0;
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            locked_reg <= locked_next;
            count_reg  <= count_next;
            stage_reg  <= stage_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < clwq_pkg::WAIT_DEPTH; i++) begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: hw/rtl/clwq_checker.sv
// ---------------------------------------------------------------------------
// clwq_checker
// Port-level checks on the result channel, and on s_ready while no result waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "channel_lock_wait_queue_macros.svh"

module clwq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input clwq_pkg::rsp_t m_data
);

    `CLWQ_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `CLWQ_ASSERT_NOW(a_notify_ok, m_valid && m_data.notify_valid, m_data.result_code == clwq_pkg::RC_OK)
    `CLWQ_ASSERT_NOW(a_notify_zero, m_valid && !m_data.notify_valid, m_data.notify_device == '0)
    `CLWQ_ASSERT_NOW(a_code_range, m_valid, m_data.result_code <= clwq_pkg::RC_REFUSED)
    `CLWQ_ASSERT_NOW(a_ready_free, !m_valid, s_ready)

endmodule

bind channel_lock_wait_queue clwq_checker u_clwq_checker (.*);
